// ===== src/bsmm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsmm_pkg
// Shared types, codes and constants of the bank switched memory map.
// ----------------------------------------------------------------------------
package bsmm_pkg;

  // expansion memory address width and the scan line that ends vblank
  localparam int EXPANSION_ADDR_BITS = 16;
  localparam int VBLANK_END_LINE     = 200;

  // clear sweep covers the largest memory
  localparam int CLR_BITS = (EXPANSION_ADDR_BITS > 16) ? EXPANSION_ADDR_BITS : 16;

  // operation codes
  localparam logic [3:0] OP_MEM_RD    = 4'd0;
  localparam logic [3:0] OP_MEM_WR    = 4'd1;
  localparam logic [3:0] OP_IO_RD     = 4'd2;
  localparam logic [3:0] OP_IO_WR     = 4'd3;
  localparam logic [3:0] OP_LINE      = 4'd4;
  localparam logic [3:0] OP_HBLANK_END = 4'd5;
  localparam logic [3:0] OP_TEMPO     = 4'd6;
  localparam logic [3:0] OP_BLINK     = 4'd7;
  localparam logic [3:0] OP_ROM_LOAD  = 4'd8;

  // device targets
  localparam logic [1:0] TGT_NONE  = 2'd0;
  localparam logic [1:0] TGT_PIO   = 2'd1;
  localparam logic [1:0] TGT_TIMER = 2'd2;
  localparam logic [1:0] TGT_GATE  = 2'd3;

  // io ports
  localparam logic [7:0] PORT_PTR_LO  = 8'h00;
  localparam logic [7:0] PORT_PTR_MID = 8'h01;
  localparam logic [7:0] PORT_PTR_HI  = 8'h02;
  localparam logic [7:0] PORT_EXP_DATA = 8'h03;
  localparam logic [7:0] PORT_BANK_E0 = 8'hE0;
  localparam logic [7:0] PORT_BANK_E1 = 8'hE1;
  localparam logic [7:0] PORT_BANK_E2 = 8'hE2;
  localparam logic [7:0] PORT_BANK_E3 = 8'hE3;
  localparam logic [7:0] PORT_BANK_E4 = 8'hE4;
  localparam logic [7:0] PORT_ID      = 8'hF7;

  // address map
  localparam logic [15:0] ROM_END   = 16'h1000;
  localparam logic [15:0] VRAM_LO   = 16'hD000;
  localparam logic [15:0] VRAM_HI   = 16'hDFFF;
  localparam logic [15:0] MMIO_HI   = 16'hE7FF;

  // byte constants
  localparam logic [7:0] BYTE_OPEN   = 8'hFF;
  localparam logic [7:0] PORT_ID_VAL = 8'h80;
  localparam logic [7:0] STATUS_BASE = 8'h7E;
  localparam logic [7:0] VRAM_ATTR_INIT = 8'h71;
  localparam logic [7:0] PC_VBLANK   = 8'h80;
  localparam logic [7:0] PC_BLINK    = 8'h40;

  // where read data comes from
  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_MAIN,
    SRC_VRAM,
    SRC_ROM,
    SRC_EXP
  } src_t;

  // architectural registers
  typedef struct packed {
    logic [1:0]                     bank;
    logic [EXPANSION_ADDR_BITS-1:0] ptr;
    logic                           hblank;
    logic                           tempo;
    logic                           blink;
  } state_t;

  // memory command for one accepted word
  typedef struct packed {
    logic                           main_we;
    logic                           vram_we;
    logic                           rom_we;
    logic                           exp_we;
    logic [15:0]                    addr;
    logic [EXPANSION_ADDR_BITS-1:0] ptr;
    logic [7:0]                     data;
  } cmd_t;

  // read data registered by the memories
  typedef struct packed {
    logic [7:0] main;
    logic [7:0] vram;
    logic [7:0] rom;
    logic [7:0] exp;
  } rd_t;

  // result fields known at decode time
  typedef struct packed {
    src_t       src;
    logic [7:0] rd_const;
    logic       wait_cycles;
    logic       request_bus;
    logic       release_bus;
    logic [1:0] device_target;
    logic [1:0] device_register;
    logic       device_is_write;
    logic [7:0] device_data;
    logic [7:0] portc_mask;
    logic [7:0] portc_value;
  } res_t;

endpackage

// ===== src/bsmm_in_if.sv =====
// ----------------------------------------------------------------------------
// bsmm_in_if
// Request channel: bus operations and timing events.
// ----------------------------------------------------------------------------
interface bsmm_in_if;
  import bsmm_pkg::*;

  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [15:0] address;
  logic [7:0]  data;
  logic [8:0]  line_number;

  modport source (output valid, operation, address, data, line_number, input ready);
  modport sink   (input valid, operation, address, data, line_number, output ready);
endinterface

// ===== src/bsmm_out_if.sv =====
// ----------------------------------------------------------------------------
// bsmm_out_if
// Response channel: one word per request.
// ----------------------------------------------------------------------------
interface bsmm_out_if;
  import bsmm_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       wait_cycles;
  logic       request_bus;
  logic       release_bus;
  logic [1:0] device_target;
  logic [1:0] device_register;
  logic       device_is_write;
  logic [7:0] device_data;
  logic [7:0] portc_mask;
  logic [7:0] portc_value;

  modport source (output valid, read_data, wait_cycles, request_bus, release_bus,
                  device_target, device_register, device_is_write, device_data,
                  portc_mask, portc_value, input ready);
  modport sink   (input valid, read_data, wait_cycles, request_bus, release_bus,
                  device_target, device_register, device_is_write, device_data,
                  portc_mask, portc_value, output ready);
endinterface

// ===== src/bsmm_decode.sv =====
// ----------------------------------------------------------------------------
// bsmm_decode
// Address and port decode: memory command, result fields and next registers.
// ----------------------------------------------------------------------------
module bsmm_decode (
  input  logic [3:0]       operation,
  input  logic [15:0]      address,
  input  logic [7:0]       data,
  input  logic [8:0]       line_number,
  input  bsmm_pkg::state_t st,
  output bsmm_pkg::state_t st_next,
  output bsmm_pkg::cmd_t   cmd,
  output bsmm_pkg::res_t   res
);
  import bsmm_pkg::*;

  logic [23:0] ptr_ext;
  logic        wr;
  logic [3:0]  nib;
  logic [7:0]  port;

  assign ptr_ext = 24'(st.ptr);
  assign wr      = (operation == OP_MEM_WR);
  assign nib     = address[3:0];
  assign port    = address[7:0];

  always_comb begin
    st_next = st;

    cmd.main_we = 1'b0;
    cmd.vram_we = 1'b0;
    cmd.rom_we  = 1'b0;
    cmd.exp_we  = 1'b0;
    cmd.addr    = address;
    cmd.ptr     = st.ptr;
    cmd.data    = data;

    res = '0;
    res.src = SRC_CONST;

    unique case (operation)
      // memory access through the bank map
      OP_MEM_RD, OP_MEM_WR: begin
        res.wait_cycles = st.bank[0] && (address < ROM_END);
        if (st.bank[1] && address >= VRAM_LO) begin
          if (address <= VRAM_HI) begin
            res.request_bus = st.hblank;
            if (wr) cmd.vram_we = 1'b1;
            else    res.src = SRC_VRAM;
          end else if (address <= MMIO_HI) begin
            if (nib < 4'd8) begin
              res.device_target   = (nib < 4'd4) ? TGT_PIO : TGT_TIMER;
              res.device_register = address[1:0];
              res.device_is_write = wr;
              res.device_data     = wr ? data : 8'd0;
            end else if (nib == 4'd8) begin
              if (wr) begin
                res.device_target   = TGT_GATE;
                res.device_is_write = 1'b1;
                res.device_data     = data;
              end else begin
                res.rd_const = STATUS_BASE | {st.hblank, 6'd0, st.tempo};
              end
            end else if (!wr) begin
              res.rd_const = BYTE_OPEN;
            end
          end else if (!wr) begin
            res.rd_const = BYTE_OPEN;
          end
        end else if (st.bank[0] && address < ROM_END) begin
          if (!wr) res.src = SRC_ROM;
        end else begin
          if (wr) cmd.main_we = 1'b1;
          else    res.src = SRC_MAIN;
        end
      end

      // io port read
      OP_IO_RD: begin
        unique case (port)
          PORT_PTR_LO:   res.rd_const = ptr_ext[7:0];
          PORT_PTR_MID:  res.rd_const = ptr_ext[15:8];
          PORT_PTR_HI:   res.rd_const = ptr_ext[23:16];
          PORT_EXP_DATA: begin
            res.src    = SRC_EXP;
            st_next.ptr = st.ptr + 1'b1;
          end
          PORT_ID:       res.rd_const = PORT_ID_VAL;
          default:       res.rd_const = BYTE_OPEN;
        endcase
      end

      // io port write
      OP_IO_WR: begin
        unique case (port)
          PORT_PTR_LO:   st_next.ptr = EXPANSION_ADDR_BITS'({ptr_ext[23:8], data});
          PORT_PTR_MID:  st_next.ptr = EXPANSION_ADDR_BITS'({ptr_ext[23:16], data,
                                                             ptr_ext[7:0]});
          PORT_PTR_HI:   st_next.ptr = EXPANSION_ADDR_BITS'({data, ptr_ext[15:0]});
          PORT_EXP_DATA: begin
            cmd.exp_we  = 1'b1;
            st_next.ptr = st.ptr + 1'b1;
          end
          PORT_BANK_E0:  st_next.bank = {st.bank[1], 1'b0};
          PORT_BANK_E1:  st_next.bank = {1'b0, st.bank[0]};
          PORT_BANK_E2:  st_next.bank = {st.bank[1], 1'b1};
          PORT_BANK_E3:  st_next.bank = {1'b1, st.bank[0]};
          PORT_BANK_E4:  st_next.bank = 2'b11;
          default:       ;
        endcase
      end

      // scan line start: sets hblank; vblank on port c bit 7 is set at line 0, cleared at VBLANK_END_LINE
      OP_LINE: begin
        if (line_number == 9'd0) begin
          res.portc_mask  = PC_VBLANK;
          res.portc_value = PC_VBLANK;
        end else if (line_number == 9'(VBLANK_END_LINE)) begin
          res.portc_mask  = PC_VBLANK;
        end
        st_next.hblank = 1'b1;
      end

      OP_HBLANK_END: begin
        st_next.hblank  = 1'b0;
        res.release_bus = 1'b1;
      end

      OP_TEMPO: st_next.tempo = ~st.tempo;

      // blink toggles port c bit 6
      OP_BLINK: begin
        st_next.blink   = ~st.blink;
        res.portc_mask  = PC_BLINK;
        res.portc_value = st.blink ? 8'd0 : PC_BLINK;
      end

      OP_ROM_LOAD: cmd.rom_we = 1'b1;

      default: ;
    endcase
  end

endmodule

// ===== src/bsmm_store.sv =====
// ----------------------------------------------------------------------------
// bsmm_store
// Main, video, boot and expansion memories with the post-reset clear sweep.
// ----------------------------------------------------------------------------
module bsmm_store (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  bsmm_pkg::cmd_t cmd,
  output logic           busy,
  output bsmm_pkg::rd_t  rd
);
  import bsmm_pkg::*;

  logic [7:0] main_mem [65536];
  logic [7:0] vram_mem [4096];
  logic [7:0] rom_mem  [4096];
  logic [7:0] exp_mem  [1 << EXPANSION_ADDR_BITS];

  logic [CLR_BITS-1:0] clr;
  logic [7:0]          vram_init;
  logic [7:0]          rd_main;
  logic [7:0]          rd_vram;
  logic [7:0]          rd_rom;
  logic [7:0]          rd_exp;

  // attribute area of video ram (0x800 to 0xBFF) is initialized to 0x71
  assign vram_init = (clr[11:10] == 2'b10) ? VRAM_ATTR_INIT : 8'd0;

  // registered read data of all memories
  assign rd.main = rd_main;
  assign rd.vram = rd_vram;
  assign rd.rom  = rd_rom;
  assign rd.exp  = rd_exp;

  // clear sweep sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clr  <= '0;
    end else if (busy) begin
      clr <= clr + 1'b1;
      if (clr == {CLR_BITS{1'b1}}) busy <= 1'b0;
    end
  end

  // main ram
  always_ff @(posedge clk) begin
    if (busy) main_mem[clr[15:0]] <= 8'd0;
    else if (accept && cmd.main_we) main_mem[cmd.addr] <= cmd.data;
    if (accept) rd_main <= main_mem[cmd.addr];
  end

  // video ram
  always_ff @(posedge clk) begin
    if (busy) vram_mem[clr[11:0]] <= vram_init;
    else if (accept && cmd.vram_we) vram_mem[cmd.addr[11:0]] <= cmd.data;
    if (accept) rd_vram <= vram_mem[cmd.addr[11:0]];
  end

  // boot rom, written by rom load
  always_ff @(posedge clk) begin
    if (busy) rom_mem[clr[11:0]] <= BYTE_OPEN;
    else if (accept && cmd.rom_we) rom_mem[cmd.addr[11:0]] <= cmd.data;
    if (accept) rd_rom <= rom_mem[cmd.addr[11:0]];
  end

  // expansion ram at the pointer
  always_ff @(posedge clk) begin
    if (busy) exp_mem[clr[EXPANSION_ADDR_BITS-1:0]] <= 8'd0;
    else if (accept && cmd.exp_we) exp_mem[cmd.ptr] <= cmd.data;
    if (accept) rd_exp <= exp_mem[cmd.ptr];
  end

endmodule

// ===== src/bank_switched_memory_map.sv =====
// ----------------------------------------------------------------------------
// bank_switched_memory_map
// An accepted request word passes the memory-read stage and the output word
// register to its response word. Throughput: one word per cycle unless
// rsp.ready stalls, set by the single read port of each memory. Reset:
// registers return to bank 3, pointer 0, flags clear; then a clear sweep of
// 2**CLR_BITS (65536) addresses initializes the memories, taking no request.
// ----------------------------------------------------------------------------
module bank_switched_memory_map (
  input  logic      clk,
  input  logic      rst,
  bsmm_in_if.sink   req,
  bsmm_out_if.source rsp
);
  import bsmm_pkg::*;

  state_t st;
  state_t st_next;
  cmd_t   cmd;
  res_t   res;
  res_t   s1_res;
  rd_t    rd;
  logic   busy;
  logic   accept;
  logic   s1_valid;
  logic   s1_adv;
  logic [7:0] rd_sel;

  bsmm_decode u_decode (
    .operation   (req.operation),
    .address     (req.address),
    .data        (req.data),
    .line_number (req.line_number),
    .st          (st),
    .st_next     (st_next),
    .cmd         (cmd),
    .res         (res)
  );

  bsmm_store u_store (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .busy   (busy),
    .rd     (rd)
  );

  // handshake
  assign s1_adv    = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !rst && !busy && (!s1_valid || s1_adv);
  assign accept    = req.valid && req.ready;

  // read data select
  always_comb begin
    unique case (s1_res.src)
      SRC_MAIN: rd_sel = rd.main;
      SRC_VRAM: rd_sel = rd.vram;
      SRC_ROM:  rd_sel = rd.rom;
      SRC_EXP:  rd_sel = rd.exp;
      default:  rd_sel = s1_res.rd_const;
    endcase
  end

  // registers and memory-read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st.bank   <= 2'b11;
      st.ptr    <= '0;
      st.hblank <= 1'b0;
      st.tempo  <= 1'b0;
      st.blink  <= 1'b0;
      s1_valid  <= 1'b0;
    end else begin
      if (accept) st <= st_next;
      if (accept) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
    end
    if (accept) s1_res <= res;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (s1_adv) begin
      rsp.read_data       <= rd_sel;
      rsp.wait_cycles     <= s1_res.wait_cycles;
      rsp.request_bus     <= s1_res.request_bus;
      rsp.release_bus     <= s1_res.release_bus;
      rsp.device_target   <= s1_res.device_target;
      rsp.device_register <= s1_res.device_register;
      rsp.device_is_write <= s1_res.device_is_write;
      rsp.device_data     <= s1_res.device_data;
      rsp.portc_mask      <= s1_res.portc_mask;
      rsp.portc_value     <= s1_res.portc_value;
    end
  end

endmodule
